/* hdl/efd_pkg.sv */
// Package with item types and codes of the elevator floor dispatch unit.
`default_nettype none

package efd_pkg;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [1:0] REQ_ORDER  = 2'd0;
  localparam logic [1:0] REQ_BUTTON = 2'd1;
  localparam logic [1:0] REQ_SENSOR = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] floor;
    logic       sensor_valid;
    logic [7:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motor_dir;
    logic [1:0] cur_floor;
    logic       door_open;
    logic [1:0] prior_dir;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/elevator_floor_dispatch_unit.sv */
// Top level of the elevator floor dispatch unit: order bits, direction choice, result register.
//
// Usage: events enter on in_valid/in_ready/in_data (assigned order, inside button,
// floor sensor). Motor commands and arrival reports leave on out_valid/out_ready/out_data,
// at most one per event; events that change nothing give none. cfg_wr_en writes the
// node id in the same cycle, with no wait; write it only while the unit is idle.
// An event accepted into the input register is decided from there; its result, if
// any, is loaded into the result register that drives out_valid. One event is taken
// every cycle while the receiver keeps up: the input register feeds a single pass of
// mask and popcount logic that updates the car state and loads the result register
// in the same cycle. A stalled receiver holds the result register; the input register
// still takes one more event, then in_ready drops until the result is taken.
// Reset clears all orders, sets direction stop and floor zero, marks the next floor
// arrival for reporting, clears node id to zero and empties both registers.
`default_nettype none

module elevator_floor_dispatch_unit #(
  parameter int FLOORS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire efd_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output efd_pkg::out_item_t     out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [7:0]        cfg_wr_data
);

  localparam int CNT_W = $clog2(FLOORS + 1);

  function automatic logic [CNT_W-1:0] pop_cnt(input logic [FLOORS-1:0] v);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < FLOORS; i++) begin
      c = c + CNT_W'(v[i]);
    end
    return c;
  endfunction

  // state
  logic [7:0]        node_id_r;
  logic [FLOORS-1:0] order_r, order_nxt;
  logic [1:0]        dir_r, dir_nxt;
  logic [1:0]        last_floor_r, last_floor_nxt;
  logic              pending_r, pending_nxt;

  // pipeline registers
  efd_pkg::in_item_t  in_q_r;
  logic               in_q_valid_r;
  efd_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r;
  logic               emit;

  logic proc;
  assign proc     = in_q_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_q_valid_r || proc;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // decode of the item held in the input register
  logic              fl_ok, hit, is_order;
  logic [FLOORS-1:0] fl_bit, set_bits, clr_bits;
  logic [FLOORS-1:0] above_m, below_m, ge_m, le_m;
  logic [FLOORS-1:0] ch_bits;
  logic [1:0]        ch_floor, ch_dir;
  logic [CNT_W-1:0]  up_cnt, dn_cnt;

  assign fl_ok    = 32'(in_q_r.floor) < FLOORS;
  assign fl_bit   = {{(FLOORS-1){1'b0}}, 1'b1} << in_q_r.floor;
  assign hit      = |(order_r & fl_bit);
  assign set_bits = order_r | fl_bit;
  assign clr_bits = order_r & ~fl_bit;
  assign is_order = (in_q_r.req_type == efd_pkg::REQ_BUTTON) ||
                    ((in_q_r.req_type == efd_pkg::REQ_ORDER) &&
                     (in_q_r.target_id == node_id_r));

  // direction choice: orders seen from ch_floor
  always_comb begin
    if (in_q_r.req_type == efd_pkg::REQ_SENSOR) begin
      ch_floor = in_q_r.floor;
      ch_bits  = hit ? clr_bits : order_r;
    end else begin
      ch_floor = last_floor_r;
      ch_bits  = set_bits;
    end
    for (int i = 0; i < FLOORS; i++) begin
      above_m[i] = i > 32'(ch_floor);
      below_m[i] = i < 32'(ch_floor);
      ge_m[i]    = i >= 32'(ch_floor);
      le_m[i]    = i <= 32'(ch_floor);
    end
    up_cnt = pop_cnt(ch_bits & above_m);
    dn_cnt = pop_cnt(ch_bits & below_m);
    if (up_cnt == '0 && dn_cnt == '0) begin
      ch_dir = efd_pkg::DIR_STOP;
    end else if (up_cnt > dn_cnt) begin
      ch_dir = efd_pkg::DIR_UP;
    end else begin
      ch_dir = efd_pkg::DIR_DOWN;
    end
  end

  always_comb begin
    order_nxt      = order_r;
    dir_nxt        = dir_r;
    last_floor_nxt = last_floor_r;
    pending_nxt    = pending_r;
    emit           = 1'b0;
    out_nxt.motor_dir = dir_r;
    out_nxt.cur_floor = last_floor_r;
    out_nxt.door_open = 1'b0;
    out_nxt.prior_dir = efd_pkg::DIR_STOP;
    case (in_q_r.req_type)
      efd_pkg::REQ_ORDER, efd_pkg::REQ_BUTTON: begin
        if (is_order && fl_ok) begin
          order_nxt = set_bits;
          if (dir_r == efd_pkg::DIR_STOP) begin
            dir_nxt = ch_dir;
            emit    = 1'b1;
          end
        end
      end
      efd_pkg::REQ_SENSOR: begin
        if (!in_q_r.sensor_valid) begin
          pending_nxt = 1'b1;
        end else if (fl_ok) begin
          last_floor_nxt = in_q_r.floor;
          pending_nxt    = 1'b0;
          if (hit) begin
            // serve: clear the order, open the door, re-decide
            order_nxt = clr_bits;
            emit      = 1'b1;
            out_nxt.door_open = 1'b1;
            out_nxt.prior_dir = dir_r;
            if (clr_bits == '0) begin
              dir_nxt = efd_pkg::DIR_STOP;
            end else if (dir_r == efd_pkg::DIR_UP) begin
              if ((clr_bits & ge_m) == '0) dir_nxt = efd_pkg::DIR_DOWN;
            end else if (dir_r == efd_pkg::DIR_DOWN) begin
              if ((clr_bits & le_m) == '0) dir_nxt = efd_pkg::DIR_UP;
            end else begin
              dir_nxt = ch_dir;
            end
          end else begin
            // stopped car with orders left picks a direction again
            if (dir_r == efd_pkg::DIR_STOP && order_r != '0) dir_nxt = ch_dir;
            emit = pending_r || (dir_nxt != dir_r);
          end
        end
      end
      default: begin
      end
    endcase
    out_nxt.motor_dir = dir_nxt;
    out_nxt.cur_floor = last_floor_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= '0;
      order_r      <= '0;
      dir_r        <= efd_pkg::DIR_STOP;
      last_floor_r <= '0;
      pending_r    <= 1'b1;
      in_q_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) node_id_r <= cfg_wr_data;
      if (in_ready) in_q_valid_r <= in_valid;
      if (proc) begin
        order_r      <= order_nxt;
        dir_r        <= dir_nxt;
        last_floor_r <= last_floor_nxt;
        pending_r    <= pending_nxt;
        out_valid_r  <= emit;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_q_r <= in_data;
    if (proc && emit) out_r <= out_nxt;
  end

endmodule

`default_nettype wire
